FILE: rtl/mbsh_pkg.sv
// shared types and constants for the byte stream murmur2 hash
`default_nettype none

package mbsh_pkg;

    localparam logic [31:0] MixMul    = 32'h5bd1e995;
    localparam int          MixShift  = 24;
    localparam int          FinShiftA = 13;
    localparam int          FinShiftB = 15;
    localparam logic [31:0] SeedReset = 32'd5381;
    localparam int          QueueDepth = 4;

    // apb register map, byte addresses
    localparam logic [2:0]  AddrSeed  = 3'd0;

    // one command from the front end to the mixing engine
    typedef struct packed {
        logic        init;      // restart the hash from init_val
        logic        mix;       // word holds a full block to fold in
        logic        fin;       // finalize and emit a hash
        logic        tail;      // word holds leftover tail bytes
        logic [31:0] init_val;
        logic [31:0] word;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_H,
        ST_TAIL,
        ST_FIN,
        ST_OUT
    } t_bstate;

endpackage

`default_nettype wire

FILE: rtl/mbsh_if.sv
// valid/ready channel interfaces for key bytes and finished hashes
`default_nettype none

interface mbsh_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [30:0] key_length;
    logic        first_item;
    logic        last_item;

    modport source (output valid, data_byte, key_length, first_item, last_item, input ready);
    modport sink   (input valid, data_byte, key_length, first_item, last_item, output ready);
endinterface

interface mbsh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/murmur2_byte_stream_hash_top.sv
// top level of the byte stream murmur2 hash with apb seed register
`default_nettype none

// MurmurHash2 (32-bit) over a key streamed one byte per transfer. The first
// transfer of a key carries the key length, which is XORed into the seed
// register (apb byte address 0, reset 5381) to start the hash; a zero-length
// first transfer carries no byte. The transfer with last_item set produces
// exactly one hash transfer on the output channel, no other transfer does.
// A front end takes a byte every cycle while its command queue has room and
// packs bytes into little-endian words. A mixing engine behind the queue owns
// the single 32x32 multiplier: a full word steps through states K1, K2, H
// after its issue, for a sustained one byte per cycle while the output is
// not held. Ending a key runs the tail multiply if tail bytes remain, then
// the final multiply and output load, after the word mix if it closes a
// full word. Output results sit in a register so the engine keeps going
// while a finished hash waits. Write the seed only while the block is idle.
module murmur2_byte_stream_hash_top #(
    parameter int QUEUE_DEPTH = mbsh_pkg::QueueDepth
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mbsh_in_if.sink      i_in,
    mbsh_out_if.source   o_out,
    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire [2:0]    paddr,
    input  wire [31:0]   pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0]    r_seed;
    logic           cfg_wr;

    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;
    mbsh_pkg::t_cmd q_in;
    mbsh_pkg::t_cmd q_out;

    // apb access: writes land in the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    // only the seed sits in the map, only the upper address bit is decoded
    assign prdata = (paddr[2] == mbsh_pkg::AddrSeed[2]) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mbsh_pkg::SeedReset;
        end else if (cfg_wr && (paddr[2] == mbsh_pkg::AddrSeed[2])) begin
            r_seed <= pwdata;
        end
    end

    // byte packing and command issue
    mbsh_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_seed  (r_seed),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    // decouples byte intake from multiplier stalls
    mbsh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // word mixing, tail fold and final mixes
    mbsh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // a command is never written into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command queue overflow");

    // the engine never takes a command from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("command queue underflow");

    // every accepted last byte issues a command, so no hash is lost
    a_last_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_item) |-> q_push)
        else $error("last transfer issued no command");
`endif

endmodule

`default_nettype wire

FILE: rtl/mbsh_front.sv
// front end: takes key bytes, packs little-endian words, issues commands
`default_nettype none

module mbsh_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    mbsh_in_if.sink          i_in,
    input  wire [31:0]       i_seed,
    input  wire              i_full,
    output logic             o_push,
    output mbsh_pkg::t_cmd   o_cmd
);

    logic [31:0] r_wb;
    logic [1:0]  r_cnt;
    logic [31:0] n_wb;
    logic [1:0]  n_cnt;

    logic        accept;
    logic        take;
    logic [31:0] wb0;
    logic [1:0]  cnt0;
    logic [31:0] wb1;
    logic        mix;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    always_comb begin
        // a zero-length first item carries no byte
        take = !(i_in.first_item && (i_in.key_length == '0));
        wb0  = i_in.first_item ? 32'd0 : r_wb;
        cnt0 = i_in.first_item ? 2'd0 : r_cnt;
        wb1  = take ? (wb0 | (32'(i_in.data_byte) << {cnt0, 3'b000})) : wb0;
        mix  = take && (cnt0 == 2'd3);

        o_cmd.init     = i_in.first_item;
        o_cmd.mix      = mix;
        o_cmd.fin      = i_in.last_item;
        o_cmd.tail     = take && !mix;
        o_cmd.init_val = i_seed ^ {1'b0, i_in.key_length};
        o_cmd.word     = wb1;

        // bytes that only fill the buffer need no command
        o_push = accept && (i_in.first_item || mix || i_in.last_item);

        if (i_in.last_item || mix) begin
            n_wb  = 32'd0;
            n_cnt = 2'd0;
        end else begin
            n_wb  = wb1;
            n_cnt = take ? cnt0 + 2'd1 : cnt0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb  <= 32'd0;
            r_cnt <= 2'd0;
        end else if (accept) begin
            r_wb  <= n_wb;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mbsh_queue.sv
// small command fifo between front end and mixing engine
`default_nettype none

module mbsh_queue #(
    parameter int DEPTH = mbsh_pkg::QueueDepth
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  mbsh_pkg::t_cmd   i_cmd,
    input  wire              i_pop,
    output mbsh_pkg::t_cmd   o_cmd,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    mbsh_pkg::t_cmd r_mem [DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;

    assign o_full  = (r_cnt == CntFull);
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + CntW'(1);
            2'b01:   n_cnt = r_cnt - CntW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + PtrW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mbsh_back.sv
// mixing engine: one shared 32x32 multiplier stepped by a sequencer
`default_nettype none

module mbsh_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  mbsh_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    mbsh_out_if.source       o_out
);

    mbsh_pkg::t_bstate r_state;
    mbsh_pkg::t_bstate n_state;

    logic [31:0] r_hash;
    logic [31:0] r_k;
    logic [31:0] r_word;
    logic        r_fin;
    logic [31:0] r_out;
    logic        r_out_valid;

    logic [31:0] mul_a;
    logic [31:0] prod;
    logic        out_free;
    logic        load_out;

    assign out_free    = !r_out_valid || o_out.ready;
    assign prod        = mul_a * mbsh_pkg::MixMul;
    assign o_out.valid = r_out_valid;
    assign o_out.hash_value = r_out;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbsh_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    if (i_cmd.mix) begin
                        n_state = mbsh_pkg::ST_K1;
                    end else if (i_cmd.fin) begin
                        n_state = i_cmd.tail ? mbsh_pkg::ST_TAIL : mbsh_pkg::ST_FIN;
                    end
                end
            end
            mbsh_pkg::ST_K1:   n_state = mbsh_pkg::ST_K2;
            mbsh_pkg::ST_K2:   n_state = mbsh_pkg::ST_H;
            mbsh_pkg::ST_H:    n_state = r_fin ? mbsh_pkg::ST_FIN : mbsh_pkg::ST_IDLE;
            mbsh_pkg::ST_TAIL: n_state = mbsh_pkg::ST_FIN;
            mbsh_pkg::ST_FIN:  n_state = mbsh_pkg::ST_OUT;
            mbsh_pkg::ST_OUT:  n_state = out_free ? mbsh_pkg::ST_IDLE : mbsh_pkg::ST_OUT;
            default:           n_state = mbsh_pkg::ST_IDLE;
        endcase
    end

    // outputs: pop strobe, multiplier operand, output load
    always_comb begin
        o_pop    = 1'b0;
        mul_a    = 32'd0;
        load_out = 1'b0;
        unique case (r_state)
            mbsh_pkg::ST_IDLE: o_pop = !i_empty;
            mbsh_pkg::ST_K1:   mul_a = r_word;
            mbsh_pkg::ST_K2:   mul_a = r_k ^ (r_k >> mbsh_pkg::MixShift);
            mbsh_pkg::ST_H:    mul_a = r_hash;
            mbsh_pkg::ST_TAIL: mul_a = r_hash ^ r_word;
            mbsh_pkg::ST_FIN:  mul_a = r_hash ^ (r_hash >> mbsh_pkg::FinShiftA);
            mbsh_pkg::ST_OUT:  load_out = out_free;
            default:           mul_a = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mbsh_pkg::ST_IDLE;
            r_hash      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop && i_cmd.init) begin
                r_hash <= i_cmd.init_val;
            end else if (r_state == mbsh_pkg::ST_H) begin
                r_hash <= prod ^ r_k;
            end else if (r_state == mbsh_pkg::ST_TAIL) begin
                // the tail-mixed hash stays as the running hash
                r_hash <= prod;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_cmd.word;
            r_fin  <= i_cmd.fin;
        end
        if (r_state == mbsh_pkg::ST_K1 || r_state == mbsh_pkg::ST_K2 ||
            r_state == mbsh_pkg::ST_FIN) begin
            r_k <= prod;
        end
        if (load_out) begin
            r_out <= r_k ^ (r_k >> mbsh_pkg::FinShiftB);
        end
    end

endmodule

`default_nettype wire
